// ===== hw/rtl/dot_star_pattern_matcher_unit_defines.svh =====
// Assertion macros shared by the matcher checker.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef DOT_STAR_PATTERN_MATCHER_UNIT_DEFINES_SVH
`define DOT_STAR_PATTERN_MATCHER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define DSPM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DSPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dspm_pkg.sv =====
// Shared types and constants for the dot-star pattern matcher.
// No dependencies; used by every matcher module except the checker.
`timescale 1ns / 1ps
`default_nettype none

package dspm_pkg;

    // Pattern geometry
    localparam int MAX_TOKENS_DEF  = 16;
    localparam int TOKEN_W         = 8;
    localparam int TOKENS_PER_WORD = 8;
    localparam int LEN_FIELD_W     = 5;
    localparam int STAR_FIELD_W    = 16;

    // Configuration port
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_TOKENS_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TOKENS_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STAR_MASK   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN = 2'd3;

    // Token byte that matches any text byte
    localparam logic [TOKEN_W-1:0] WILDCARD_BYTE = 8'd46;

    typedef logic [TOKEN_W-1:0] byte_t;

    // Per-cell pattern setup
    typedef struct packed {
        byte_t token;
        logic  star;
        logic  active;
    } tok_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dspm_cell.sv =====
// One pattern token cell: holds one prefix-match bit and ripples the star closure.
// Depends on dspm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dspm_cell (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  dspm_pkg::tok_cfg_t tok,
    input  dspm_pkg::byte_t    text_byte,
    input  wire                logic present,
    input  wire                logic step,
    input  wire                logic clear,
    input  wire                logic clos_in,
    output logic               clos_out,
    input  wire                logic fin_in,
    output logic               fin_out
);
    import dspm_pkg::*;

    logic bit_reg;
    logic bit_next;
    logic hit;
    logic new_bit;

    // Compare token against the text byte
    assign hit = (tok.token == WILDCARD_BYTE) || (tok.token == text_byte);

    // Extend the closure through a starred token
    assign clos_out = bit_reg || (clos_in && tok.star && tok.active);

    // Advance the prefix bit on a text byte
    assign bit_next = tok.active && hit && (clos_in || (tok.star && clos_out));

    // Closure of the vector after this request, for the end-of-text result
    assign new_bit = present ? bit_next : bit_reg;
    assign fin_out = new_bit || (fin_in && tok.star && tok.active);

    // Hold, advance or drop the prefix bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else if (clear)
        begin
            bit_reg <= 1'b0;
        end
        else if (step)
        begin
            bit_reg <= bit_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dspm_chain.sv =====
// Row of token cells plus the empty-prefix bit and the result select.
// Depends on dspm_pkg and dspm_cell.
`timescale 1ns / 1ps
`default_nettype none

module dspm_chain #(
    parameter int MAX_TOKENS = dspm_pkg::MAX_TOKENS_DEF,
    parameter int LEN_W      = $clog2(MAX_TOKENS + 1)
) (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  dspm_pkg::tok_cfg_t tok [MAX_TOKENS],
    input  wire                logic [LEN_W-1:0] len,
    input  dspm_pkg::byte_t    text_byte,
    input  wire                logic accept,
    input  wire                logic present,
    input  wire                logic last,
    output logic               matched
);
    import dspm_pkg::*;

    logic               bit0_reg;
    logic [MAX_TOKENS:0] clos;
    logic [MAX_TOKENS:0] fin;
    logic               step;
    logic               clear;

    assign step  = accept && present;
    assign clear = accept && last;

    // Empty prefix: cleared by a text byte, set again at end of text
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit0_reg <= 1'b1;
        end
        else if (clear)
        begin
            bit0_reg <= 1'b1;
        end
        else if (step)
        begin
            bit0_reg <= 1'b0;
        end
    end

    assign clos[0] = bit0_reg;
    assign fin[0]  = present ? 1'b0 : bit0_reg;

    // Cell i holds prefix bit i+1
    for (genvar g = 0; g < MAX_TOKENS; g++)
    begin : g_cell
        dspm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .tok       (tok[g]),
            .text_byte (text_byte),
            .present   (present),
            .step      (step),
            .clear     (clear),
            .clos_in   (clos[g]),
            .clos_out  (clos[g+1]),
            .fin_in    (fin[g]),
            .fin_out   (fin[g+1])
        );
    end

    // Whole pattern matched when the closure reaches the active length
    assign matched = fin[len];

endmodule

`default_nettype wire

// ===== hw/rtl/dot_star_pattern_matcher_unit.sv =====
// Top level of the dot-star pattern matcher: configuration registers and result register.
// Depends on dspm_pkg, dspm_chain and dspm_cell.
`timescale 1ns / 1ps
`default_nettype none

// Matches a whole text against a pattern of up to MAX_TOKENS tokens (literal bytes or
// the wildcard '.', each optionally starred). One text request is taken every clock
// cycle unless stalled; the prefix-match bits live in a row of MAX_TOKENS cells, and
// the star closure ripples across that row within the cycle, so the row length sets
// the critical path. The request that carries end_of_text yields one matched result,
// shown on out_valid in the cycle after it is accepted; the vector then returns to the
// start state. in_stall rises only while a finished result is held by out_stall. Write
// the configuration registers only while no text is in progress and no result is pending.
module dot_star_pattern_matcher_unit #(
    parameter int MAX_TOKENS = dspm_pkg::MAX_TOKENS_DEF
) (
    input  wire             logic clk,
    input  wire             logic rst_n,
    // Configuration
    input  wire             logic cfg_we,
    input  wire             logic [dspm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire             logic [dspm_pkg::CFG_DATA_W-1:0] cfg_data,
    // Text requests
    input  wire             logic in_valid,
    output logic            in_stall,
    input  dspm_pkg::byte_t text_byte,
    input  wire             logic byte_present,
    input  wire             logic end_of_text,
    // Results
    output logic            out_valid,
    input  wire             logic out_stall,
    output logic            matched
);
    import dspm_pkg::*;

    localparam int LEN_W = $clog2(MAX_TOKENS + 1);

    byte_t                 token_reg [MAX_TOKENS];
    logic [MAX_TOKENS-1:0] star_reg;
    logic [MAX_TOKENS-1:0] active_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [LEN_FIELD_W-1:0] len_raw;
    logic [LEN_FIELD_W-1:0] len_sat;
    tok_cfg_t              tok [MAX_TOKENS];
    logic                  in_accept;
    logic                  chain_matched;
    logic                  out_valid_reg;
    logic                  matched_reg;

    // Token bytes: each slot loads from its half of the pattern
    for (genvar g = 0; g < MAX_TOKENS; g++)
    begin : g_token
        localparam int WORD = g / TOKENS_PER_WORD;
        localparam int SLOT = g % TOKENS_PER_WORD;
        localparam logic [CFG_INDEX_W-1:0] TOK_REG =
            (WORD == 0) ? REG_TOKENS_LOW : REG_TOKENS_HIGH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                token_reg[g] <= '0;
            end
            else if (cfg_we && (cfg_index == TOK_REG))
            begin
                token_reg[g] <= cfg_data[SLOT*TOKEN_W +: TOKEN_W];
            end
        end

        assign tok[g].token  = token_reg[g];
        assign tok[g].star   = star_reg[g];
        assign tok[g].active = active_reg[g];
    end

    // Saturate the pattern length to the cell count
    assign len_raw = cfg_data[LEN_FIELD_W-1:0];
    assign len_sat = (len_raw > LEN_FIELD_W'(MAX_TOKENS)) ? LEN_FIELD_W'(MAX_TOKENS) : len_raw;

    // Star mask, length and per-cell enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            star_reg   <= '0;
            active_reg <= '0;
            len_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STAR_MASK:
                begin
                    star_reg <= cfg_data[MAX_TOKENS-1:0];
                end
                REG_PATTERN_LEN:
                begin
                    len_reg <= LEN_W'(len_sat);
                    for (int i = 0; i < MAX_TOKENS; i++)
                    begin
                        active_reg[i] <= (LEN_FIELD_W'(i) < len_sat);
                    end
                end
                default:
                begin
                    star_reg <= star_reg;
                end
            endcase
        end
    end

    // Take a request unless a result is held
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    dspm_chain #(
        .MAX_TOKENS (MAX_TOKENS),
        .LEN_W      (LEN_W)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (tok),
        .len       (len_reg),
        .text_byte (text_byte),
        .accept    (in_accept),
        .present   (byte_present),
        .last      (end_of_text),
        .matched   (chain_matched)
    );

    // Result register: load at end of text, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept && end_of_text)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && end_of_text)
        begin
            matched_reg <= chain_matched;
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dspm_checker.sv =====
// Port-level checks for the dot-star pattern matcher, bound to the top level.
// Depends on dot_star_pattern_matcher_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "dot_star_pattern_matcher_unit_defines.svh"

module dspm_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic end_of_text,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic matched
);

    // A held result keeps its value
    `DSPM_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid && $stable(matched), "result changed while stalled")

    // Input stalls only behind a held result
    `DSPM_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a held result")

    // An accepted end of text gives a result next cycle
    `DSPM_ASSERT_NEXT(a_result_follows, in_valid && !in_stall && end_of_text, out_valid, "missing result after end of text")

    // A new result only follows an accepted end of text
    `DSPM_ASSERT_SAME(a_result_source, $rose(out_valid), $past(in_valid && !in_stall && end_of_text), "result without end of text")

endmodule

bind dot_star_pattern_matcher_unit dspm_checker u_dspm_checker (.*);

`default_nettype wire
